// File: hw/rtl/ilp_pkg.sv
// ---------------------------------------------------------------------------
// ilp_pkg: shared types and constants for the integer literal parser
// Character codes, parser phase, radix and status encodings, parser state.
// ---------------------------------------------------------------------------
package ilp_pkg;

    localparam int unsigned VALUE_W = 64;

    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_B  = 8'h62;  // 'b'
    localparam logic [7:0] CH_LO_F  = 8'h66;  // 'f'
    localparam logic [7:0] CH_LO_X  = 8'h78;  // 'x'

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_ZERO,
        PH_DIGIT,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        RX_DEC,
        RX_BIN,
        RX_HEX
    } t_radix;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD,
        ST_LABEL
    } t_status;

    typedef struct packed {
        t_phase               phase;
        logic                 negative;
        t_radix               radix;
        logic [VALUE_W-1:0]   acc;     // kept with the sign already applied
        t_status              err;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:    PH_START,
        negative: 1'b0,
        radix:    RX_DEC,
        acc:      '0,
        err:      ST_OK
    };

endpackage

// File: hw/rtl/ilp_if.sv
// ---------------------------------------------------------------------------
// ilp_if: request channels of the integer literal parser
// Character input channel and parsed value output channel, valid/ready.
// ---------------------------------------------------------------------------
interface ilp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ilp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ilp_pkg::VALUE_W-1:0] value;
    logic [1:0]                         status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// File: hw/rtl/ilp_step.sv
// ---------------------------------------------------------------------------
// ilp_step: next-state logic of the parser for one character
// Phase transitions, digit decode and signed accumulate, end-of-token result.
// ---------------------------------------------------------------------------
module ilp_step (
    input  ilp_pkg::t_state             i_state,
    input  logic [7:0]                  i_ch,
    output ilp_pkg::t_state             o_state,
    output logic [ilp_pkg::VALUE_W-1:0] o_value,
    output ilp_pkg::t_status            o_status
);

    ilp_pkg::t_radix             rx;
    logic                        take;
    logic                        dig_ok;
    logic [3:0]                  dig;
    logic [ilp_pkg::VALUE_W-1:0] sdig;
    logic [ilp_pkg::VALUE_W-1:0] acc_next;
    logic                        is_dec;
    logic                        is_hex_lo;

    assign is_dec    = (i_ch >= ilp_pkg::CH_ZERO) && (i_ch <= ilp_pkg::CH_NINE);
    assign is_hex_lo = (i_ch >= ilp_pkg::CH_LO_A) && (i_ch <= ilp_pkg::CH_LO_F);

    // radix in force for a digit taken on this character
    always_comb begin
        case (i_state.phase)
            ilp_pkg::PH_DIGIT: rx = i_state.radix;
            default:           rx = ilp_pkg::RX_DEC;
        endcase
    end

    // digit decode
    always_comb begin
        dig_ok = 1'b0;
        dig    = 4'd0;
        case (rx)
            ilp_pkg::RX_BIN: begin
                dig_ok = (i_ch == ilp_pkg::CH_ZERO) || (i_ch == ilp_pkg::CH_ONE);
                dig    = {3'b000, i_ch[0]};
            end
            ilp_pkg::RX_HEX: begin
                if (is_dec) begin
                    dig_ok = 1'b1;
                    dig    = i_ch[3:0];
                end else if (is_hex_lo) begin
                    dig_ok = 1'b1;
                    dig    = 4'(i_ch - ilp_pkg::CH_LO_A + 8'd10);
                end
            end
            default: begin
                dig_ok = is_dec;
                dig    = i_ch[3:0];
            end
        endcase
    end

    // digit carries the sign, so acc never needs a final negate
    assign sdig = i_state.negative ? (ilp_pkg::VALUE_W'(0) - ilp_pkg::VALUE_W'(dig))
                                   : ilp_pkg::VALUE_W'(dig);

    always_comb begin
        case (rx)
            ilp_pkg::RX_BIN: acc_next = (i_state.acc << 1) + sdig;
            ilp_pkg::RX_HEX: acc_next = (i_state.acc << 4) + sdig;
            default:         acc_next = (i_state.acc << 3) + (i_state.acc << 1) + sdig;
        endcase
    end

    always_comb begin
        o_state = i_state;
        take    = 1'b0;
        case (i_state.phase)
            ilp_pkg::PH_START: begin
                if (i_ch == ilp_pkg::CH_MINUS) begin
                    o_state.negative = 1'b1;
                    o_state.phase    = ilp_pkg::PH_SIGN;
                end else if (i_ch == ilp_pkg::CH_ZERO) begin
                    o_state.phase = ilp_pkg::PH_ZERO;
                end else if (is_dec) begin
                    take = 1'b1;
                end else begin
                    o_state.err   = ilp_pkg::ST_LABEL;
                    o_state.phase = ilp_pkg::PH_ERROR;
                end
            end
            ilp_pkg::PH_SIGN: begin
                if (i_ch == ilp_pkg::CH_ZERO) begin
                    o_state.phase = ilp_pkg::PH_ZERO;
                end else begin
                    take = 1'b1;
                end
            end
            ilp_pkg::PH_ZERO: begin
                if (i_ch == ilp_pkg::CH_LO_B) begin
                    o_state.radix = ilp_pkg::RX_BIN;
                    o_state.phase = ilp_pkg::PH_DIGIT;
                end else if (i_ch == ilp_pkg::CH_LO_X) begin
                    o_state.radix = ilp_pkg::RX_HEX;
                    o_state.phase = ilp_pkg::PH_DIGIT;
                end else begin
                    take = 1'b1;
                end
            end
            ilp_pkg::PH_DIGIT: begin
                take = 1'b1;
            end
            default: begin
                take = 1'b0;
            end
        endcase

        if (take) begin
            if (dig_ok) begin
                o_state.acc   = acc_next;
                o_state.radix = rx;
                o_state.phase = ilp_pkg::PH_DIGIT;
            end else begin
                o_state.err   = ilp_pkg::ST_BAD;
                o_state.phase = ilp_pkg::PH_ERROR;
            end
        end
    end

    assign o_status = o_state.err;
    assign o_value  = (o_state.err == ilp_pkg::ST_OK) ? o_state.acc : '0;

endmodule

// File: hw/rtl/integer_literal_parser_unit.sv
// ---------------------------------------------------------------------------
// integer_literal_parser_unit: streaming integer literal parser
// Parses one operand token (decimal, 0b binary, 0x hex, optional minus)
// into a signed 64-bit value, one character per request.
// ---------------------------------------------------------------------------
// Usage:
//   i_in  carries one ASCII character per request, last set on the final
//         character of the token. Any number of tokens follow back to back.
//   o_out carries one request per token: the 64-bit two's complement value
//         (wrapping modulo 2^64) and a status: ok, bad digit, or label.
//         The value is zero when the status is not ok.
// Timing:
//   A character is registered at acceptance and parsed from the input
//   register by one pass of the step logic; a final character's result
//   lands in the output register (o_out.valid) at the parsing edge. One
//   character per cycle is sustained while o_out is not held; the critical
//   path is the decimal accumulate (acc*8 + acc*2 + digit, one 3-input add).
// Stall: while o_out is held, a waiting final character stays in the
//   input register and i_in.ready drops; non-final characters keep flowing
//   since they produce no output.
// Reset: synchronous, active low; clears both stage valids and returns the
//   parser to the start of a token.
// ---------------------------------------------------------------------------
module integer_literal_parser_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ilp_in_if.sink           i_in,
    ilp_out_if.source        o_out
);

    // input stage
    logic                         r_in_valid;
    logic [7:0]                   r_ch;
    logic                         r_last;

    // parser state
    ilp_pkg::t_state              r_st;
    ilp_pkg::t_state              n_st;

    // output stage
    logic                         r_out_valid;
    logic [ilp_pkg::VALUE_W-1:0]  r_value;
    ilp_pkg::t_status             r_status;
    logic [ilp_pkg::VALUE_W-1:0]  n_value;
    ilp_pkg::t_status             n_status;

    logic                         out_free;
    logic                         fire;
    logic                         emit;

    ilp_step u_step (
        .i_state  (r_st),
        .i_ch     (r_ch),
        .o_state  (n_st),
        .o_value  (n_value),
        .o_status (n_status)
    );

    // a final character may only be parsed when the output slot is free
    assign out_free   = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && (!r_last || out_free);
    assign emit       = fire && r_last;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ch   <= i_in.ch;
            r_last <= i_in.last;
        end
    end

    // parser state: back to start after each token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ilp_pkg::STATE_RESET;
        end else if (fire) begin
            r_st <= r_last ? ilp_pkg::STATE_RESET : n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_value;
    assign o_out.status = r_status;

endmodule
